// File: rtl/pcm_pkg.sv
// Shared constants, types and helpers of the permutation cycle marker.
package pcm_pkg;

	// Table size and derived widths
	localparam int MAX_ELEMENTS = 1024;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int IDX_W        = 10;
	localparam int CNT_W        = 11;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Stream widths: index and value packed, padded to whole bytes
	localparam int S_TDATA_W = ((2 * IDX_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((CNT_W + 7) / 8) * 8;

	// Request kinds carried on tuser
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic clr;
		logic load;
		logic start;
		logic step;
		logic add;
		logic emit;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clr_last;
		logic stop;
		logic out_free;
	} sts_t;

	// True when an element number names a table entry
	function automatic logic in_range(input logic [IDX_W-1:0] x);
		return (32'(x) < 32'(MAX_ELEMENTS));
	endfunction

endpackage

// File: rtl/pcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/pcm_ctrl.sv
// Controller state machine: clearing pass, request intake, cycle walk, result hand-off.
module pcm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tuser,
	output logic          s_tready,
	input  pcm_pkg::sts_t sts,
	output pcm_pkg::cmd_t cmd
);
	import pcm_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid && s_tuser == MODE_QUERY) state_nxt = ST_WALK;
			end
			ST_WALK: begin
				if (sts.stop) state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			ST_IDLE: begin
				s_tready  = 1'b1;
				cmd.start = s_tvalid && s_tuser == MODE_QUERY;
				cmd.load  = s_tvalid && s_tuser == MODE_LOAD;
			end
			ST_WALK: begin
				cmd.add  = sts.stop;
				cmd.step = !sts.stop;
			end
			ST_FINISH: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: rtl/pcm_datapath.sv
// Datapath: permutation and mark memories, walk cursor, counters and result register.
module pcm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pcm_pkg::S_TDATA_W-1:0] s_tdata,
	input  pcm_pkg::cmd_t                 cmd,
	output pcm_pkg::sts_t                 sts,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [pcm_pkg::M_TDATA_W-1:0] m_tdata
);
	import pcm_pkg::*;

	logic [IDX_W-1:0]  req_idx;
	logic [IDX_W-1:0]  req_val;
	logic              req_ok;

	logic [IDX_W-1:0]  perm_rd;
	logic              vis_rd;
	logic [ADDR_W-1:0] rd_addr;
	logic              vis_we;
	logic [ADDR_W-1:0] vis_waddr;
	logic              vis_wdata;
	logic              perm_we;

	logic [ADDR_W-1:0] clr_q;
	logic [IDX_W-1:0]  cur_q;
	logic              cur_ok_q;
	logic              byp_q;
	logic [CNT_W-1:0]  walk_q;
	logic [CNT_W-1:0]  total_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  out_data_q;
	logic [CNT_W:0]    sum;

	assign req_idx = s_tdata[IDX_W-1:0];
	assign req_val = s_tdata[2*IDX_W-1:IDX_W];
	assign req_ok  = in_range(req_idx);

	// Read the requested element on start, else the next element of the walk
	assign rd_addr = cmd.start ? ADDR_W'(req_idx) : ADDR_W'(perm_rd);

	// Mark writes: clear sweep, clear on load, set on walk step
	always_comb begin
		vis_we    = 1'b0;
		vis_waddr = clr_q;
		vis_wdata = 1'b0;
		if (cmd.clr) begin
			vis_we = 1'b1;
		end else if (cmd.load) begin
			vis_we    = req_ok;
			vis_waddr = ADDR_W'(req_idx);
		end else if (cmd.step) begin
			vis_we    = 1'b1;
			vis_waddr = ADDR_W'(cur_q);
			vis_wdata = 1'b1;
		end
	end

	assign perm_we = cmd.load && req_ok;

	pcm_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_ELEMENTS)
	) u_perm (
		.clk  (clk),
		.we   (perm_we),
		.waddr(ADDR_W'(req_idx)),
		.wdata(req_val),
		.raddr(rd_addr),
		.rdata(perm_rd)
	);

	pcm_ram #(
		.WIDTH(1),
		.DEPTH(MAX_ELEMENTS)
	) u_vis (
		.clk  (clk),
		.we   (vis_we),
		.waddr(vis_waddr),
		.wdata(vis_wdata),
		.raddr(rd_addr),
		.rdata(vis_rd)
	);

	// Saturating add of the walk length to the total
	assign sum = {1'b0, total_q} + {1'b0, walk_q};

	// Clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr && !sts.clr_last) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Walk cursor; the bypass flag covers an element that maps onto itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_ok_q <= 1'b0;
			byp_q    <= 1'b0;
			walk_q   <= '0;
		end else if (cmd.start) begin
			cur_ok_q <= req_ok;
			byp_q    <= 1'b0;
			walk_q   <= '0;
		end else if (cmd.step) begin
			cur_ok_q <= in_range(perm_rd);
			byp_q    <= (perm_rd == cur_q);
			if (walk_q != CNT_MAX) walk_q <= walk_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cur_q <= req_idx;
		end else if (cmd.step) begin
			cur_q <= perm_rd;
		end
	end

	// Running total: reset by an accepted load, grown at the end of a walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.load && req_ok) begin
			total_q <= '0;
		end else if (cmd.add) begin
			total_q <= sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= total_q;
		end
	end

	assign sts.clr_last = (clr_q == ADDR_W'(MAX_ELEMENTS - 1));
	assign sts.stop     = !cur_ok_q || vis_rd || byp_q;
	assign sts.out_free = !out_valid_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(out_data_q);

endmodule

// File: rtl/permutation_cycle_marker_core.sv
// Top level of the permutation cycle marker: controller plus datapath.
//
//  Channel | Direction | Bus     | Contents (lowest bit first)
//  --------+-----------+---------+---------------------------------------------
//  s_*     | in        | tdata   | index[9:0], value[19:10], zero pad to 24
//          |           | tuser   | mode (0 load entry, 1 query element)
//  m_*     | out       | tdata   | total_marked[10:0], zero pad to 16
//
// A load gives no result and does not hold up the next request. A query walks the
// cycle from its element and marks each element it newly reaches: the walk reads
// one table entry and one mark per cycle through the single read port of each
// memory. The next request is taken once the result has gone into the output
// register, which happens when that register is free. After reset a clearing pass
// zeroes all 1024 marks; no request is taken during it. A result waiting in the
// output register does not block further loads; a following query holds its
// result until the register frees.
module permutation_cycle_marker_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pcm_pkg::S_TDATA_W-1:0] s_tdata,   // index, value
	input  logic                          s_tuser,   // mode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pcm_pkg::M_TDATA_W-1:0] m_tdata    // total_marked
);
	import pcm_pkg::*;

	cmd_t cmd;
	sts_t sts;
	sts_t sts_hs;

	// Let the result register free up in the cycle it is taken
	always_comb begin
		sts_hs          = sts;
		sts_hs.out_free = sts.out_free || m_tready;
	end

	pcm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tuser (s_tuser),
		.s_tready(s_tready),
		.sts     (sts_hs),
		.cmd     (cmd)
	);

	logic dp_valid;

	pcm_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.sts     (sts),
		.m_tready(m_tready),
		.m_tvalid(dp_valid),
		.m_tdata (m_tdata)
	);

	assign m_tvalid = dp_valid;

endmodule

// File: rtl/pcm_checker.sv
// Port-level checker for the permutation cycle marker, bound to the top level.
module pcm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pcm_pkg::M_TDATA_W-1:0] m_tdata
);
	import pcm_pkg::*;

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A load finishes in its own cycle: the next request can follow at once
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == MODE_LOAD |=> s_tready)
		else $error("intake blocked after a load");

	// A query occupies the block for at least the following cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == MODE_QUERY |=> !s_tready)
		else $error("intake open during a walk");

	// A query never produces its result in the cycle right after acceptance
	a_query_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == MODE_QUERY |=> !$rose(m_tvalid))
		else $error("result appeared too early");

endmodule

bind permutation_cycle_marker_core pcm_checker u_pcm_checker (.*);

// File: verif/pcm_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the permutation cycle marker testbench: table copy and expected totals.
package pcm_tb_pkg;

	import pcm_pkg::*;

	class cycle_mark_tracker;
		logic [IDX_W-1:0] image [MAX_ELEMENTS];
		bit               written [MAX_ELEMENTS];
		bit               marked [MAX_ELEMENTS];
		logic [CNT_W-1:0] total;
		logic [CNT_W-1:0] pending_totals [$];
		int               errors;
		int               loads;
		int               queries;
		int               results;
		int               peak_total;

		function new();
			foreach (image[i]) begin
				image[i]   = '0;
				written[i] = 1'b0;
				marked[i]  = 1'b0;
			end
			total      = '0;
			errors     = 0;
			loads      = 0;
			queries    = 0;
			results    = 0;
			peak_total = 0;
		endfunction

		// True when a query of start would only read table entries already written
		function bit walk_is_defined(logic [IDX_W-1:0] start);
			bit seen [MAX_ELEMENTS];
			int cur;
			cur = int'(start);
			while (cur < MAX_ELEMENTS && !marked[cur] && !seen[cur]) begin
				if (!written[cur])
					return 1'b0;
				seen[cur] = 1'b1;
				cur = int'(image[cur]);
			end
			return 1'b1;
		endfunction

		// Apply one accepted request; a query queues the total it must return
		function void take_request(logic mode, logic [IDX_W-1:0] idx, logic [IDX_W-1:0] val);
			int cur;
			int newly;
			int sum;
			if (mode == MODE_LOAD) begin
				loads++;
				if (int'(idx) < MAX_ELEMENTS) begin
					image[idx]   = val;
					written[idx] = 1'b1;
					marked[idx]  = 1'b0;
					total        = '0;
				end
				return;
			end
			queries++;
			newly = 0;
			if (int'(idx) < MAX_ELEMENTS && !marked[idx]) begin
				cur = int'(idx);
				// walk the cycle until an already marked element or a dangling image
				while (cur < MAX_ELEMENTS && !marked[cur]) begin
					marked[cur] = 1'b1;
					if (newly < int'(CNT_MAX))
						newly++;
					cur = int'(image[cur]);
				end
				sum   = int'(total) + newly;
				total = (sum > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(sum);
			end
			pending_totals = {pending_totals, total};
		endfunction

		// Compare one returned total with the oldest expectation
		function void match_total(logic [CNT_W-1:0] got);
			logic [CNT_W-1:0] want;
			if (pending_totals.size() == 0) begin
				$error("total_marked: result with nothing expected, expected none, actual %0d", got);
				errors++;
				return;
			end
			want = pending_totals.pop_front();
			results++;
			if (got !== want) begin
				$error("total_marked mismatch: expected %0d, actual %0d", want, got);
				errors++;
			end
			if (int'(want) > peak_total)
				peak_total = int'(want);
		endfunction
	endclass

endpackage

// File: verif/permutation_cycle_marker_core_tb.sv
`timescale 1ns / 100ps
// Testbench of permutation_cycle_marker_core: loads random mappings and checks query totals.
module permutation_cycle_marker_core_tb;

	import pcm_pkg::*;
	import pcm_tb_pkg::*;

	localparam int TARGET_ITEMS = 650;
	localparam int QUIET_LIMIT  = 4000;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tuser  = MODE_LOAD;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	cycle_mark_tracker board = new();

	int send_idle_pct  = 12;
	int recv_stall_pct = 49;
	int items_sent     = 0;
	int quiet_cycles   = 0;

	permutation_cycle_marker_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// Check results, randomize backpressure and watch for a stuck pipeline
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.match_total(m_tdata[CNT_W-1:0]);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Send one request, with random idle cycles in front of it
	task automatic push_request(logic mode, logic [IDX_W-1:0] idx, logic [IDX_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'({val, idx});
		s_tuser  <= mode;
		do
			@(posedge clk);
		while (!s_tready);
		board.take_request(mode, idx, val);
		items_sent++;
	endtask

	// Query only where the walk stays on written entries
	task automatic query_if_defined(logic [IDX_W-1:0] idx);
		if (board.walk_is_defined(idx))
			push_request(MODE_QUERY, idx, IDX_W'($urandom_range(MAX_ELEMENTS - 1)));
	endtask

	// Hold the sender until every expected total has come back
	task automatic drain_totals();
		s_tvalid <= 1'b0;
		while (board.pending_totals.size() != 0)
			@(posedge clk);
	endtask

	// Load a random mapping over n distinct elements, then query it with some noise
	task automatic run_cycle_set(int n);
		bit    chosen [MAX_ELEMENTS];
		int    members [$];
		int    images [$];
		int    pick;
		int    j;
		int    tmp;
		int    roll;
		bit    scrambled;
		while (members.size() < n) begin
			pick = $urandom_range(MAX_ELEMENTS - 1);
			if (!chosen[pick]) begin
				chosen[pick] = 1'b1;
				members = {members, pick};
			end
		end
		// mostly a true permutation, sometimes a mapping with collisions
		scrambled = ($urandom_range(4) == 0);
		foreach (members[k])
			images = {images, scrambled ? members[$urandom_range(n - 1)] : members[k]};
		if (!scrambled) begin
			for (int k = n - 1; k > 0; k--) begin
				j = $urandom_range(k);
				tmp = images[k];
				images[k] = images[j];
				images[j] = tmp;
			end
		end
		foreach (members[k])
			push_request(MODE_LOAD, IDX_W'(members[k]), IDX_W'(images[k]));
		for (int q = 0; q < n + 2; q++) begin
			roll = $urandom_range(99);
			if (roll < 78)
				query_if_defined(IDX_W'(members[$urandom_range(n - 1)]));
			else if (roll < 88)
				push_request(MODE_LOAD, IDX_W'(members[$urandom_range(n - 1)]),
					IDX_W'(members[$urandom_range(n - 1)]));
			else if (roll < 95)
				query_if_defined(IDX_W'($urandom_range(MAX_ELEMENTS - 1)));
			else
				push_request(MODE_LOAD, IDX_W'($urandom_range(MAX_ELEMENTS - 1)),
					IDX_W'($urandom_range(MAX_ELEMENTS - 1)));
		end
	endtask

	initial begin
		int phase;
		int n;
		bit big_done;
		phase    = 0;
		big_done = 1'b0;

		// hold reset, then release it on an edge
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// two-element cycle at the index extremes
		push_request(MODE_LOAD, 10'd0, 10'd1023);
		push_request(MODE_LOAD, 10'd1023, 10'd0);
		query_if_defined(10'd0);
		query_if_defined(10'd1023);
		// self loop: reload clears one mark and the total
		push_request(MODE_LOAD, 10'd1023, 10'd1023);
		query_if_defined(10'd1023);
		query_if_defined(10'd0);
		// alternating bit patterns
		push_request(MODE_LOAD, 10'h155, 10'h2AA);
		push_request(MODE_LOAD, 10'h2AA, 10'h155);
		query_if_defined(10'h2AA);
		// not a permutation: a tail running into a loop
		push_request(MODE_LOAD, 10'd5, 10'd6);
		push_request(MODE_LOAD, 10'd6, 10'd7);
		push_request(MODE_LOAD, 10'd7, 10'd6);
		query_if_defined(10'd5);
		query_if_defined(10'd7);
		// walk that ends on an element marked earlier
		push_request(MODE_LOAD, 10'd10, 10'd5);
		query_if_defined(10'd10);
		push_request(MODE_LOAD, 10'd0, 10'd0);
		query_if_defined(10'd0);
		query_if_defined(10'd1023);
		drain_totals();

		// random sets through three idling phases
		while (items_sent < TARGET_ITEMS) begin
			if (phase == 0 && items_sent >= 230) begin
				drain_totals();
				phase          = 1;
				send_idle_pct  = 49;
				recv_stall_pct = 12;
			end else if (phase == 1 && items_sent >= 440) begin
				drain_totals();
				phase          = 2;
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			if (phase == 2 && !big_done) begin
				n = 128;
				big_done = 1'b1;
			end else if ($urandom_range(9) == 0) begin
				n = $urandom_range(40, 13);
			end else begin
				n = $urandom_range(12, 1);
			end
			run_cycle_set(n);
			if ($urandom_range(7) == 0)
				drain_totals();
		end

		drain_totals();
		repeat (16) @(posedge clk);

		$display("Sent %0d loads and %0d queries over three idling phases.",
			board.loads, board.queries);
		$display("Checked %0d totals; largest total seen %0d.",
			board.results, board.peak_total);
		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/pcm_pkg.sv
rtl/pcm_ram.sv
rtl/pcm_ctrl.sv
rtl/pcm_datapath.sv
rtl/permutation_cycle_marker_core.sv
rtl/pcm_checker.sv
verif/pcm_tb_pkg.sv
verif/permutation_cycle_marker_core_tb.sv
